>>> hw/rtl/assert_macros.svh
// Assertion macros used by the sstf_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

>>> hw/rtl/sstf_pkg.sv
// ----------------------------------------------------------------------------
// sstf_pkg
// Format codes and the reset format for the sample converter.
// ----------------------------------------------------------------------------
package sstf_pkg;
    localparam logic [3:0] FMT_IBM   = 4'd1;
    localparam logic [3:0] FMT_INT32 = 4'd2;
    localparam logic [3:0] FMT_INT16 = 4'd3;
    localparam logic [3:0] FMT_IEEE  = 4'd5;
    localparam logic [3:0] FMT_INT8  = 4'd8;
    localparam logic [3:0] FMT_RESET = FMT_IBM;
endpackage

>>> hw/rtl/sstf_pack.sv
// ----------------------------------------------------------------------------
// sstf_pack
// Packs sign * mag * 2^k (mag below 2^32) into single-precision bits, RNE.
// ----------------------------------------------------------------------------
module sstf_pack
    import sstf_pkg::*;
(
    input  logic        sign,
    input  logic [31:0] mag,
    input  logic signed [9:0] k,
    output logic [31:0] bits
);
    logic [4:0]        lz;
    logic [31:0]       norm;
    logic signed [10:0] biased;
    logic [24:0]       rsig;
    logic              guard, sticky, up;
    logic signed [10:0] bfin;
    logic [5:0]        dsh;
    logic [63:0]       shifted;
    logic [23:0]       sq;
    logic              sg, ss;

    always_comb
    begin
        lz = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                lz = 5'(31 - i);
            end
        end
        norm = mag << lz;
        // exponent of msb position p = 31 - lz
        biased = 11'(k) + 11'sd158 - 11'($unsigned(lz));
        guard = norm[7];
        sticky = |norm[6:0];
        up = guard && (sticky || norm[8]);
        rsig = {1'b0, norm[31:8]} + 25'(up);
        bfin = biased + 11'(rsig[24]);
        // subnormal: value = mag*2^k, q = round(mag * 2^(k+149))
        dsh = 6'd0;
        if (biased < 11'sd1)
        begin
            if ((11'sd1 - biased) > 11'sd30)
            begin
                dsh = 6'd63;
            end
            else
            begin
                dsh = 6'(11'sd1 - biased);
            end
        end
        // normalized significand sits at bits 63:40; shift right for subnormal
        shifted = {norm, 32'd0} >> dsh;
        sq = shifted[63:40];
        sg = shifted[39];
        ss = |shifted[38:0];
        if (mag == 32'd0)
        begin
            bits = {sign, 31'd0};
        end
        else if (biased >= 11'sd1)
        begin
            if (bfin >= 11'sd255)
            begin
                bits = {sign, 8'hff, 23'd0};
            end
            else
            begin
                bits = {sign, bfin[7:0], (rsig[24] ? rsig[23:1] : rsig[22:0])};
            end
        end
        else
        begin
            bits = {sign, 31'(sq) + 31'(sg && (ss || sq[0]))};
        end
    end
endmodule

>>> hw/rtl/segy_sample_to_float.sv
// ----------------------------------------------------------------------------
// segy_sample_to_float
// Seismic sample word to IEEE-754 single converter, one beat per cycle while out_stall is low.
// ----------------------------------------------------------------------------
//  channel  | signals                           | dir
//  in       | in_valid, in_stall, raw_word      | in (in_stall out)
//  out      | out_valid, out_stall, float_bits, format_error | out (out_stall in)
//  cfg      | cfg_we, cfg_data                  | in
// One beat per cycle while out_stall is low; a beat passes the input register, then the result register.
// Reset sets fmt_reg to IBM float and empties both stages.
// A stalled output stage holds; the input register accepts a beat when it
// is empty or when the result register is free or draining.
module segy_sample_to_float
    import sstf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] raw_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] float_bits,
    output logic        format_error
);
    logic [3:0]  fmt_reg;
    logic        s1_valid_reg;
    logic [31:0] s1_word_reg;
    logic        out_valid_reg;
    logic [31:0] bits_reg;
    logic        err_reg;
    logic        adv_out, adv_in;
    logic        sign;
    logic [31:0] mag;
    logic signed [9:0] k;
    logic [31:0] packed_bits;
    logic [31:0] bits_next;
    logic        err_next;
    logic [31:0] w;

    assign adv_out = !out_valid_reg || !out_stall;
    assign adv_in  = !s1_valid_reg || adv_out;
    assign in_stall = !adv_in;
    assign w = s1_word_reg;

    // Pick sign, magnitude and scale for the shared packer.
    always_comb
    begin
        sign = 1'b0;
        mag = 32'd0;
        k = 10'sd0;
        unique case (fmt_reg)
            FMT_IBM:
            begin
                sign = w[31];
                mag = {8'd0, w[23:0]};
                k = 10'(signed'({1'b0, w[30:24]}) - 8'sd64) * 10'sd4 - 10'sd24;
            end
            FMT_INT32:
            begin
                sign = w[31];
                mag = w[31] ? (~w + 32'd1) : w;
            end
            FMT_INT16:
            begin
                sign = w[15];
                mag = {16'd0, (w[15] ? (~w[15:0] + 16'd1) : w[15:0])};
            end
            FMT_INT8:
            begin
                sign = w[7];
                mag = {24'd0, (w[7] ? (~w[7:0] + 8'd1) : w[7:0])};
            end
            default:
            begin
            end
        endcase
    end

    sstf_pack u_pack (
        .sign (sign),
        .mag  (mag),
        .k    (k),
        .bits (packed_bits)
    );

    always_comb
    begin
        err_next = 1'b0;
        bits_next = packed_bits;
        unique case (fmt_reg)
            FMT_IBM:
            begin
                if (w == 32'd0)
                begin
                    bits_next = 32'd0;
                end
            end
            FMT_INT32, FMT_INT16, FMT_INT8:
            begin
                if (mag == 32'd0)
                begin
                    bits_next = 32'd0;
                end
            end
            FMT_IEEE:
            begin
                bits_next = w;
            end
            default:
            begin
                err_next = 1'b1;
                bits_next = 32'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_RESET;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                fmt_reg <= cfg_data;
            end
            if (adv_in)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload: load input on accept, result when the output stage advances.
    always_ff @(posedge clk)
    begin
        if (adv_in && in_valid)
        begin
            s1_word_reg <= raw_word;
        end
        if (adv_out && s1_valid_reg)
        begin
            bits_reg <= bits_next;
            err_reg <= err_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign float_bits = bits_reg;
    assign format_error = err_reg;
endmodule

>>> hw/rtl/sstf_checker.sv
// ----------------------------------------------------------------------------
// sstf_checker
// Port-level checks on the sample converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sstf_checker
    import sstf_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] float_bits,
    input logic        format_error,
    input logic        in_stall
);
    `CHK_IMPLY(a_err_zero, clk, rst_n, out_valid && format_error, float_bits == 32'd0)
    `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(float_bits))
    `CHK_IMPLY(a_no_stall_free, clk, rst_n, !out_valid, !in_stall)
endmodule

bind segy_sample_to_float sstf_checker u_sstf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .float_bits   (float_bits),
    .format_error (format_error),
    .in_stall     (in_stall)
);
